// ----- hdl/prdh_pkg.sv -----
// ----------------------------------------------------------------------------
// prdh_pkg: shared types and constants for the daily power histogram
// Register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package prdh_pkg;

  localparam int NUM_BUCKETS_DEF = 20;

  localparam logic [1:0] REG_BUCKET_WIDTH = 2'd0;
  localparam logic [1:0] REG_BAR_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_TARIFF       = 2'd2;

  localparam logic [15:0] BUCKET_WIDTH_RST = 16'd100;
  localparam logic [7:0]  BAR_HEIGHT_RST   = 8'd48;
  localparam logic [15:0] TARIFF_RST       = 16'd150;

  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_BIDX, ST_ACC, ST_MAX, ST_AVG_N, ST_AVG_D,
    ST_COST_M, ST_COST_N, ST_COST_D, ST_BAR_D, ST_OUT
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

// ----- hdl/prdh_div.sv -----
// ----------------------------------------------------------------------------
// prdh_div: shared restoring divider
// 64-bit by 32-bit unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prdh_div import prdh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] q;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], q[63]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= req.num;
        den  <= req.den;
        rem  <= '0;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

// ----- hdl/power_reading_daily_histogram.sv -----
// ----------------------------------------------------------------------------
// power_reading_daily_histogram: daily power histogram from meter reports
// Accumulates per-day totals and a pulse histogram; emits one result per
// bucket with bar height and day summary.
// ----------------------------------------------------------------------------
// One report is taken at a time. After acceptance a small sequencer runs:
// the clear pass walks the bucket memory (one entry a cycle, writing zeros
// only on a day change), the bucket index comes from the shared divider,
// the bucket is updated with a read and a write, the maximum is found by
// walking the buckets, average and cost each take one divider pass after
// their set-up, and then each bucket result needs its own divider pass for
// the bar height before it goes to the output register. A zero duration
// total skips both divider passes, an empty histogram skips the bar
// divisions, and m_tready can hold a result back. s_tready is high only
// while idle.
// A finished result sits in the output register until its transfer.
// ----------------------------------------------------------------------------
module power_reading_daily_histogram import prdh_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // day_of_year[8:0], watts[24:9], pulses[40:25], duration_ms[72:41], pad
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bucket_index[4:0], bar_height[12:5], min_watts[28:13],
  // day_pulse_total[44:29], average_watts[68:45], cost_thousandths[100:69]
  output logic [103:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int BW = $clog2(NUM_BUCKETS);

  // configuration
  logic [15:0] bucket_width, tariff;
  logic [7:0]  bar_area;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width <= BUCKET_WIDTH_RST;
      bar_area     <= BAR_HEIGHT_RST;
      tariff       <= TARIFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUCKET_WIDTH: bucket_width <= cfg_data;
        REG_BAR_HEIGHT:   bar_area     <= cfg_data[7:0];
        REG_TARIFF:       tariff       <= cfg_data;
        default: ;
      endcase
    end
  end

  // day state
  logic        day_known;
  logic [8:0]  current_day;
  logic [15:0] lowest, pulse_total;
  logic [31:0] dur_total;
  logic [15:0] in_watts, in_pulses;

  // bucket memory
  logic [31:0] mem [NUM_BUCKETS];
  logic [31:0] rd_data;
  logic [BW-1:0] rd_addr;
  logic [BW-1:0] ptr;
  logic [BW-1:0] bidx;
  logic          mem_we;
  logic [BW-1:0] wr_addr;
  logic [31:0]   wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // sequencer
  state_t state, state_next;
  logic   started;
  logic [31:0] maxc;
  logic [23:0] avg;
  logic [31:0] cost;
  logic [63:0] prod;
  logic [7:0]  bar;
  logic        phase;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquo;

  prdh_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quo(dquo));

  logic [32:0] acc_sum;
  assign acc_sum = {1'b0, rd_data} + {17'd0, in_pulses};
  logic [32:0] dur_sum;
  // pulses * 86400 fits 33 bits; times the tariff fits 49
  logic [48:0] cost_prod;
  assign cost_prod = prod[32:0] * tariff;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CLEAR;
      ST_CLEAR:  if (ptr == BW'(NUM_BUCKETS - 1)) state_next = ST_BIDX;
      ST_BIDX:   if (ddone) state_next = ST_ACC;
      ST_ACC:    if (phase) state_next = ST_MAX;
      ST_MAX:    if (phase && ptr == BW'(NUM_BUCKETS - 1)) state_next = ST_AVG_N;
      ST_AVG_N:  state_next = ST_AVG_D;
      ST_AVG_D:  if (ddone || dur_total == 0) state_next = ST_COST_M;
      ST_COST_M: state_next = ST_COST_N;
      ST_COST_N: state_next = ST_COST_D;
      ST_COST_D: if (ddone || dur_total == 0) state_next = ST_BAR_D;
      ST_BAR_D:  if (phase && (ddone || maxc == 0)) state_next = ST_OUT;
      ST_OUT:    if (m_tvalid && m_tready)
                   state_next = (ptr == BW'(NUM_BUCKETS - 1)) ? ST_IDLE : ST_BAR_D;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);

  always_comb begin
    rd_addr = ptr;
    mem_we  = 1'b0;
    wr_addr = ptr;
    wr_data = '0;
    dreq    = '0;
    if (state == ST_CLEAR) mem_we = started;
    if (state == ST_ACC) begin
      rd_addr = bidx;
      wr_addr = bidx;
      mem_we  = phase;
      wr_data = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    end
    // fetch the next bucket while its predecessor waits for its transfer
    if (state == ST_OUT && ptr != BW'(NUM_BUCKETS - 1)) rd_addr = ptr + 1'b1;
    if (state == ST_CLEAR && ptr == BW'(NUM_BUCKETS - 1)) begin
      dreq.start = 1'b1;
      dreq.num   = {48'd0, in_watts};
      dreq.den   = (bucket_width == 0) ? 32'd1 : {16'd0, bucket_width};
    end
    if (state == ST_AVG_N && dur_total != 0) begin
      dreq.start = 1'b1;
      dreq.num   = prod + {33'd0, dur_total[31:1]};
      dreq.den   = dur_total;
    end
    if (state == ST_COST_N && dur_total != 0) begin
      dreq.start = 1'b1;
      dreq.num   = prod + {33'd0, dur_total[31:1]};
      dreq.den   = dur_total;
    end
    if (state == ST_BAR_D && !phase && maxc != 0) begin
      dreq.start = 1'b1;
      dreq.num   = 64'(bar_area) * 64'(rd_data);
      dreq.den   = maxc;
    end
  end

  assign dur_sum = {1'b0, dur_total} + {1'b0, s_tdata[72:41]};

  always_ff @(posedge clk) begin
    if (rst) begin
      day_known <= 1'b0;
      current_day <= '0;
      lowest <= '0;
      pulse_total <= '0;
      dur_total <= '0;
      ptr <= '0;
      started <= 1'b0;
      phase <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (s_tvalid) begin
          in_watts  <= s_tdata[24:9];
          in_pulses <= s_tdata[40:25];
          ptr <= '0;
          if (!day_known || s_tdata[8:0] != current_day) begin
            day_known   <= 1'b1;
            current_day <= s_tdata[8:0];
            lowest      <= s_tdata[24:9];
            pulse_total <= s_tdata[40:25];
            dur_total   <= s_tdata[72:41];
            started     <= 1'b1;
          end else begin
            if (s_tdata[24:9] < lowest) lowest <= s_tdata[24:9];
            pulse_total <= pulse_total + s_tdata[40:25];
            dur_total   <= dur_sum[32] ? 32'hFFFF_FFFF : dur_sum[31:0];
            started     <= 1'b0;
          end
        end
        ST_CLEAR: if (ptr != BW'(NUM_BUCKETS - 1)) ptr <= ptr + 1'b1;
        ST_BIDX: if (ddone) begin
          bidx  <= (dquo >= 64'(NUM_BUCKETS)) ? BW'(NUM_BUCKETS - 1) : dquo[BW-1:0];
          phase <= 1'b0;
        end
        ST_ACC: begin
          phase <= ~phase;
          if (phase) begin
            ptr <= '0;
            maxc <= '0;
          end
        end
        ST_MAX: begin
          // phase 0: address issued; phase 1: data compared
          phase <= ~phase;
          if (phase) begin
            if (rd_data > maxc) maxc <= rd_data;
            if (ptr != BW'(NUM_BUCKETS - 1)) ptr <= ptr + 1'b1;
            else prod <= 64'(pulse_total) * 64'(MS_PER_HOUR);
          end
        end
        ST_AVG_D: begin
          // divider holds its own copy of the numerator
          prod <= 64'(pulse_total) * 64'(SEC_PER_DAY);
          if (dur_total == 0) avg <= '0;
          else if (ddone) avg <= (dquo > 64'hFF_FFFF) ? 24'hFF_FFFF : dquo[23:0];
        end
        ST_COST_M: prod <= {15'd0, cost_prod};
        ST_COST_N: begin
          ptr <= '0;
          phase <= 1'b0;
        end
        ST_COST_D: begin
          if (dur_total == 0) cost <= '0;
          else if (ddone) cost <= (dquo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dquo[31:0];
        end
        ST_BAR_D: begin
          if (!phase) phase <= 1'b1;
          else if (maxc == 0) bar <= '0;
          else if (ddone) bar <= dquo[7:0];
        end
        ST_OUT: if (m_tready) begin
          phase <= 1'b0;
          if (ptr != BW'(NUM_BUCKETS - 1)) ptr <= ptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {3'd0, cost, avg, pulse_total, lowest, bar, 5'(ptr)};
  assign m_tlast = (ptr == BW'(NUM_BUCKETS - 1));

endmodule

// ----- hdl/prdh_checker.sv -----
// ----------------------------------------------------------------------------
// prdh_checker: port-level checks for the daily power histogram
// Watches handshakes and result order on the top-level ports.
// ----------------------------------------------------------------------------
module prdh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic         m_tlast
);

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_first: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("not idle after last result");

endmodule

bind power_reading_daily_histogram prdh_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ----- sim/power_reading_daily_histogram_test.sv -----
// ----------------------------------------------------------------------------
// power_reading_daily_histogram_test: testbench for the daily power histogram
// Drives meter reports and register writes, predicts the twenty bucket
// results of every report and compares each output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Prediction of the bucket results and the store of pending ones.
class histogram_scoreboard;
  typedef struct {
    logic [4:0]  bucket_index;
    logic [7:0]  bar_height;
    logic [15:0] min_watts;
    logic [15:0] day_pulse_total;
    logic [23:0] average_watts;
    logic [31:0] cost_thousandths;
    logic        last;
  } bucket_result_t;

  bucket_result_t pending_results[$];
  int unsigned    error_count;

  logic [15:0] width_reg;
  logic [7:0]  height_reg;
  logic [15:0] tariff_reg;
  bit          day_seen;
  logic [8:0]  day_reg;
  logic [15:0] lowest_reg;
  logic [15:0] pulse_sum;
  logic [31:0] duration_sum;
  logic [31:0] counts[20];

  function new();
    width_reg    = 16'd100;
    height_reg   = 8'd48;
    tariff_reg   = 16'd150;
    day_seen     = 1'b0;
    day_reg      = '0;
    lowest_reg   = '0;
    pulse_sum    = '0;
    duration_sum = '0;
    error_count  = 0;
    foreach (counts[i]) counts[i] = '0;
  endfunction

  function void write_reg(logic [1:0] index, logic [15:0] value);
    case (index)
      prdh_pkg::REG_BUCKET_WIDTH: width_reg = value;
      prdh_pkg::REG_BAR_HEIGHT:   height_reg = value[7:0];
      prdh_pkg::REG_TARIFF:       tariff_reg = value;
      default: ;
    endcase
  endfunction

  function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function logic [63:0] rounded_quotient(logic [63:0] num, logic [31:0] den,
                                         logic [63:0] limit);
    logic [63:0] q;
    if (den == 0) return 64'd0;
    q = (num + {32'd0, den >> 1}) / {32'd0, den};
    return (q > limit) ? limit : q;
  endfunction

  // Note one accepted report and queue its twenty results.
  function void note_report(logic [8:0] day, logic [15:0] watts,
                            logic [15:0] pulses, logic [31:0] dur);
    logic [31:0]    width;
    logic [31:0]    idx;
    logic [31:0]    maxc;
    logic [63:0]    avg;
    logic [63:0]    cost;
    logic [63:0]    h;
    bucket_result_t r;
    if (!day_seen || day != day_reg) begin
      day_seen     = 1'b1;
      day_reg      = day;
      lowest_reg   = watts;
      pulse_sum    = '0;
      duration_sum = '0;
      foreach (counts[i]) counts[i] = '0;
    end
    if (watts < lowest_reg) lowest_reg = watts;
    width = (width_reg == 0) ? 32'd1 : {16'd0, width_reg};
    idx = {16'd0, watts} / width;
    if (idx >= 20) idx = 19;
    counts[idx]  = sat_sum(counts[idx], {16'd0, pulses});
    pulse_sum    = pulse_sum + pulses;
    duration_sum = sat_sum(duration_sum, dur);
    avg  = rounded_quotient(64'(pulse_sum) * 64'd3600000, duration_sum, 64'hFF_FFFF);
    cost = rounded_quotient(64'(pulse_sum) * 64'd86400 * 64'(tariff_reg),
                            duration_sum, 64'hFFFF_FFFF);
    maxc = 0;
    foreach (counts[i]) if (counts[i] > maxc) maxc = counts[i];
    for (int i = 0; i < 20; i++) begin
      h = 0;
      if (maxc != 0) h = (64'(height_reg) * 64'(counts[i])) / 64'(maxc);
      r.bucket_index     = i[4:0];
      r.bar_height       = h[7:0];
      r.min_watts        = lowest_reg;
      r.day_pulse_total  = pulse_sum;
      r.average_watts    = avg[23:0];
      r.cost_thousandths = cost[31:0];
      r.last             = (i == 19);
      pending_results.push_back(r);
    end
  endfunction

  function void check_result(logic [103:0] data, logic tlast);
    bucket_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result transfer, data %h", data);
      error_count++;
      return;
    end
    e = pending_results.pop_front();
    if (data[4:0] !== e.bucket_index) begin
      $error("bucket_index: expected %0d, actual %0d", e.bucket_index, data[4:0]);
      error_count++;
    end
    if (data[12:5] !== e.bar_height) begin
      $error("bar_height: expected %0d, actual %0d", e.bar_height, data[12:5]);
      error_count++;
    end
    if (data[28:13] !== e.min_watts) begin
      $error("min_watts: expected %0d, actual %0d", e.min_watts, data[28:13]);
      error_count++;
    end
    if (data[44:29] !== e.day_pulse_total) begin
      $error("day_pulse_total: expected %0d, actual %0d", e.day_pulse_total,
             data[44:29]);
      error_count++;
    end
    if (data[68:45] !== e.average_watts) begin
      $error("average_watts: expected %0d, actual %0d", e.average_watts, data[68:45]);
      error_count++;
    end
    if (data[100:69] !== e.cost_thousandths) begin
      $error("cost_thousandths: expected %0d, actual %0d", e.cost_thousandths,
             data[100:69]);
      error_count++;
    end
    if (tlast !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, tlast);
      error_count++;
    end
  endfunction
endclass

module power_reading_daily_histogram_test;
  import prdh_pkg::*;

  // 465 reports, each with the worst receiver stall on every result, stay
  // well below this limit.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // day_of_year[8:0], watts[24:9], pulses[40:25], duration_ms[72:41], pad
  logic [79:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // bucket_index[4:0], bar_height[12:5], min_watts[28:13],
  // day_pulse_total[44:29], average_watts[68:45], cost_thousandths[100:69]
  logic [103:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  histogram_scoreboard board;
  int unsigned         cycle_count;
  bit                  quiet_phase;   // no idling in the closing part
  logic [8:0]          day_now;

  power_reading_daily_histogram dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("power_reading_daily_histogram_test: done, errors");
      $finish;
    end
  end

  // Result side: check at the rising edge, move tready at the falling edge.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);

  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // One register write, only while the block is idle.
  task automatic write_register(logic [1:0] index, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.write_reg(index, value);
    @(negedge clk);
  endtask

  // Wait until every queued result has transferred, then a latency margin.
  task automatic drain_results();
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Offer one report; transfer happens on a rising edge with tready high.
  task automatic send_report(logic [8:0] day, logic [15:0] watts,
                             logic [15:0] pulses, logic [31:0] dur);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tdata  <= {7'd0, dur, pulses, watts, day};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_report(day, watts, pulses, dur);
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly reports within the same day, with small durations for plausible
  // averages; now and then a day change or extreme values.
  task automatic random_report();
    logic [15:0] w;
    logic [15:0] p;
    logic [31:0] d;
    case ($urandom_range(0, 9))
      0: day_now = 9'($urandom_range(0, 511));
      1: day_now = day_now + 9'd1;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: w = 16'($urandom);
      default: w = 16'($urandom_range(0, 2500));
    endcase
    p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    case ($urandom_range(0, 5))
      0: d = $urandom;
      1: d = 32'd0;
      default: d = $urandom_range(1000, 600000);
    endcase
    send_report(day_now, w, p, d);
  endtask

  initial begin
    board       = new();
    cycle_count = 0;
    quiet_phase = 1'b0;
    day_now     = 9'd10;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_BUCKET_WIDTH;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, zero duration, empty histogram first.
    send_report(9'd0, 16'd0, 16'd0, 32'd0);
    send_report(9'd0, 16'd150, 16'd0, 32'd0);
    send_report(9'd0, 16'd50, 16'd100, 32'd0);
    send_report(9'd0, 16'hFFFF, 16'hFFFF, 32'd3600000);
    send_report(9'd1, 16'd1999, 16'd500, 32'hFFFF_FFFF);
    send_report(9'd1, 16'd2000, 16'hFFFF, 32'hFFFF_FFFF);   // duration saturates
    send_report(9'd365, 16'd5, 16'd1, 32'd1);               // one-millisecond duration
    send_report(9'd511, 16'd5, 16'd1, 32'd1);
    drain_results();

    // Extremes of every register, zero width and oversized bar area.
    write_register(REG_BUCKET_WIDTH, 16'd0);
    write_register(REG_BAR_HEIGHT, 16'd255);
    write_register(REG_TARIFF, 16'hFFFF);
    send_report(9'd2, 16'd3, 16'd7, 32'd10);
    send_report(9'd2, 16'd19, 16'd9, 32'd1);
    send_report(9'd2, 16'd1000, 16'hFFFF, 32'd0);
    drain_results();
    write_register(REG_BUCKET_WIDTH, 16'hFFFF);
    write_register(REG_BAR_HEIGHT, 16'd1);
    write_register(REG_TARIFF, 16'd0);
    send_report(9'd3, 16'hFFFF, 16'd1234, 32'd100);
    send_report(9'd3, 16'hFFFE, 16'd1, 32'd100);
    drain_results();
    write_register(REG_BUCKET_WIDTH, 16'd1);
    write_register(REG_BAR_HEIGHT, 16'd128);
    write_register(REG_TARIFF, 16'd150);
    send_report(9'd4, 16'd0, 16'd1, 32'd1000);
    send_report(9'd4, 16'd19, 16'd3, 32'd1000);
    drain_results();

    // Random phases, each with fresh settings and a full drain at its end.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_register(REG_BUCKET_WIDTH, 16'd100);
        1: write_register(REG_BUCKET_WIDTH, 16'($urandom_range(1, 400)));
        default: write_register(REG_BUCKET_WIDTH, 16'($urandom));
      endcase
      write_register(REG_BAR_HEIGHT, 16'($urandom_range(1, 255)));
      write_register(REG_TARIFF, 16'($urandom));
      if (phase == 5) quiet_phase = 1'b1;
      for (int n = 0; n < 75; n++) random_report();
      drain_results();
    end

    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("power_reading_daily_histogram_test: done, clean");
    end else begin
      $display("power_reading_daily_histogram_test: done, errors");
    end
    $finish;
  end
endmodule
